@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sspid_pkg.sv @@
// ----------------------------------------------------------------------------
// sspid_pkg
// Shared types and constants of the staged-setpoint incremental PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package sspid_pkg;

	localparam int DUTY_MAX   = 1000;
	localparam int DIV_SCALE  = 1000000;
	localparam int HIGH_SET   = 800;
	localparam int ERR_BAND   = 30;
	localparam int FLAT_LIMIT = 30;
	localparam int STAGE_EXTRA = 10;
	localparam int MUL_STEPS  = 15;
	localparam int DIV_STEPS  = 10;
	localparam int SUM_W      = 30;

	localparam logic [2:0] REG_SETPOINT  = 3'd0;
	localparam logic [2:0] REG_STEP_SIZE = 3'd1;
	localparam logic [2:0] REG_MARGIN    = 3'd2;
	localparam logic [2:0] REG_GAIN_LOW  = 3'd3;
	localparam logic [2:0] REG_GAIN_HIGH = 3'd4;
	localparam logic [2:0] REG_SW_OFFSET = 3'd5;
	localparam logic [2:0] REG_ACC_START = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [14:0] setpoint;
		logic [10:0] step_size;
		logic [10:0] step_margin;
		logic [14:0] gain_low;
		logic [14:0] gain_high;
		logic [14:0] switch_offset;
		logic [30:0] accum_start;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic                    load;
		logic signed [SUM_W-1:0] sum;
		logic [14:0]             gain;
	} mac_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/staged_setpoint_incremental_pid_core.sv @@
// ----------------------------------------------------------------------------
// staged_setpoint_incremental_pid_core
// Heater controller with staged target and incremental PID, bit-serial math.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries a temperature in tdata and the operation in tuser
// (0 starts a control run, 1 runs a control step). Each word yields one
// output word with the duty and the working target.
// A start word goes from idle to the finishing state, which loads the output
// register. A step word first runs the shift-and-add multiplier that folds
// the gain into the accumulator, then hands the sum to the divider, runs the
// restoring divider and finally loads the output register.
// One word is processed at a time; tready is high only while idle, which
// starts the cycle after the output register is loaded.
// The output register keeps one finished word; a new input is accepted
// while it waits, and the next result is held until the receiver takes it.
// Reset clears all control state, sets the integral gain to eight and the
// configuration registers to zero. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module staged_setpoint_incremental_pid_core
	import sspid_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] temperature
	input  wire logic        s_axis_tuser,  // [0] op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [9:0] duty, [25:10] working_target
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [30:0] cfg_wdata
);

	cfg_t     cfg_q;
	state_t   state_q, state_d;
	mac_cmd_t cmd;
	logic        take, mul_done, div_done, div_start, op_q, out_load;
	logic [63:0] acc;
	logic [9:0]  duty_div, duty_q;
	logic [15:0] target, target_out_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SETPOINT:  cfg_q.setpoint      <= cfg_wdata[14:0];
				REG_STEP_SIZE: cfg_q.step_size     <= cfg_wdata[10:0];
				REG_MARGIN:    cfg_q.step_margin   <= cfg_wdata[10:0];
				REG_GAIN_LOW:  cfg_q.gain_low      <= cfg_wdata[14:0];
				REG_GAIN_HIGH: cfg_q.gain_high     <= cfg_wdata[14:0];
				REG_SW_OFFSET: cfg_q.switch_offset <= cfg_wdata[14:0];
				REG_ACC_START: cfg_q.accum_start   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign take = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = s_axis_tuser ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) op_q <= s_axis_tuser;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty_q <= op_q ? duty_div : '0;
			target_out_q <= target;
		end
	end

	sspid_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .take(take), .op(s_axis_tuser),
		.temperature(s_axis_tdata), .cfg(cfg_q), .cmd(cmd), .target(target)
	);

	sspid_mac u_mac (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .accum_start(cfg_q.accum_start),
		.done(mul_done), .acc(acc)
	);

	sspid_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .acc(acc),
		.done(div_done), .duty(duty_div)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, target_out_q, duty_q};

endmodule

`default_nettype wire

@@ hw/rtl/sspid_ctrl.sv @@
// ----------------------------------------------------------------------------
// sspid_ctrl
// Staging, gain scheduling and error history; forms the PID increment sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sspid_ctrl
	import sspid_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic        op,
	input  wire logic [15:0] temperature,
	input  wire cfg_t        cfg,
	output mac_cmd_t         cmd,
	output logic [15:0]      target
);

	logic signed [15:0] peak_q, target_q, gst_q, ep_q, ep2_q;
	logic [4:0]  flat_q, ign_q, igu_q;
	logic [14:0] pg_q;
	logic        kp_q, s80_q, wh_q, ts_q, ih_q;

	logic signed [15:0] pk, tn, gst, ep, ep2, e;
	logic [4:0]  fl, ign, igu;
	logic [14:0] pg;
	logic        kp, s80, wh, tsf, ih, stg, ld;
	logic signed [17:0] t18, sp18, more18, tn18, ad18;
	logic signed [SUM_W-1:0] pi, pp, pd;

	always_comb begin
		pk = peak_q; tn = target_q; gst = gst_q; ep = ep_q; ep2 = ep2_q;
		fl = flat_q; ign = ign_q; igu = igu_q; pg = pg_q;
		kp = kp_q; s80 = s80_q; wh = wh_q; tsf = ts_q; ih = ih_q;
		stg = 1'b1; ld = 1'b0;
		t18 = {{2{temperature[15]}}, temperature};
		sp18 = {3'b000, cfg.setpoint};
		more18 = 18'(cfg.step_size) + 18'(cfg.step_margin) + 18'(STAGE_EXTRA);
		tn18 = '0; ad18 = '0; e = '0; pi = '0; pp = '0; pd = '0;
		if (!op) begin
			kp = 1'b0; s80 = 1'b0; wh = 1'b0; tsf = 1'b0; ih = 1'b0;
			if (sp18 > 18'(HIGH_SET)) begin
				gst = 16'({1'b0, cfg.setpoint} - {1'b0, cfg.switch_offset});
				s80 = 1'b1;
			end else begin
				gst = {1'b0, cfg.setpoint};
				kp = 1'b1;
			end
			pk = temperature;
			tn = temperature + 16'(cfg.step_size);
			if (tn >= $signed({1'b0, cfg.setpoint})) begin
				wh = 1'b1;
				tn = {1'b0, cfg.setpoint};
			end
			pg = cfg.gain_low; ign = 5'd8; ep = '0; ep2 = '0; ld = 1'b1;
		end else begin
			if (s80) begin
				if (!kp) begin
					if ($signed(temperature) > gst) begin
						tn = {1'b0, cfg.setpoint};
						pg = cfg.gain_high; ign = 5'd16; ep = '0; ep2 = '0; ld = 1'b1;
						kp = 1'b1; wh = 1'b1; stg = 1'b0;
					end
				end else begin
					stg = 1'b0;
					if (!tsf && t18 > sp18) begin
						pg = cfg.gain_low; ign = 5'd8; ep = '0; ep2 = '0; ld = 1'b1;
						tsf = 1'b1;
					end
				end
			end
			if (stg) begin
				tn18 = {{2{tn[15]}}, tn};
				if (tn18 > t18 + more18) begin
					tn = temperature + 16'(cfg.step_size);
					wh = 1'b0;
				end else if (!wh && tn18 + $signed({7'd0, cfg.step_margin}) < t18) begin
					tn = tn + 16'(cfg.step_size);
					if (tn > $signed({1'b0, cfg.setpoint})) begin
						tn = {1'b0, cfg.setpoint};
						wh = 1'b1;
					end
					pg = cfg.gain_low; ign = 5'd8; ep = '0; ep2 = '0; ld = 1'b1;
				end
			end
			if ($signed(temperature) > pk) begin
				pk = temperature;
				fl = '0;
			end else if (fl != 5'd31) begin
				fl = fl + 5'd1;
			end
			e = tn - temperature;
			ad18 = e[15] ? -{{2{e[15]}}, e} : {{2{e[15]}}, e};
			if ((ad18 > 18'(ERR_BAND)) ? !ih : !wh) begin
				if (fl == 5'(FLAT_LIMIT)) begin
					tn = {1'b0, cfg.setpoint};
					igu = ign;
					ih = 1'b1;
				end else begin
					igu = '0;
				end
			end else if (ad18 <= 18'(ERR_BAND)) begin
				igu = ign;
				ih = 1'b1;
			end
			pi = SUM_W'(e) * $signed({1'b0, igu});
			pp = (SUM_W'(e) - SUM_W'(ep)) * SUM_W'(1000);
			pd = (SUM_W'(e) + SUM_W'(ep2) - (SUM_W'(ep) <<< 1)) * SUM_W'(100);
			ep2 = ep;
			ep = e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0; target_q <= '0; gst_q <= '0; ep_q <= '0; ep2_q <= '0;
			flat_q <= '0; ign_q <= 5'd8; igu_q <= '0; pg_q <= '0;
			kp_q <= 1'b0; s80_q <= 1'b0; wh_q <= 1'b0; ts_q <= 1'b0; ih_q <= 1'b0;
		end else if (take) begin
			peak_q <= pk; target_q <= tn; gst_q <= gst; ep_q <= ep; ep2_q <= ep2;
			flat_q <= fl; ign_q <= ign; igu_q <= igu; pg_q <= pg;
			kp_q <= kp; s80_q <= s80; wh_q <= wh; ts_q <= tsf; ih_q <= ih;
		end
	end

	assign cmd.start = take & op;
	assign cmd.load  = take & ld;
	assign cmd.sum   = pi + pp + pd;
	assign cmd.gain  = pg;
	assign target    = target_q;

endmodule

`default_nettype wire

@@ hw/rtl/sspid_mac.sv @@
// ----------------------------------------------------------------------------
// sspid_mac
// Bit-serial multiply of the increment sum by the gain into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sspid_mac
	import sspid_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mac_cmd_t    cmd,
	input  wire logic [30:0] accum_start,
	output logic             done,
	output logic [63:0]      acc
);

	logic [63:0] acc_q, mcand_q, base;
	logic [14:0] mplier_q;
	logic [3:0]  cnt_q;
	logic        busy_q;

	assign base = cmd.load ? {33'd0, accum_start} : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; busy_q <= 1'b0; cnt_q <= '0;
		end else if (cmd.start) begin
			acc_q <= base; busy_q <= 1'b1; cnt_q <= '0;
		end else if (cmd.load) begin
			acc_q <= base;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(MUL_STEPS - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= 64'(cmd.sum);
			mplier_q <= cmd.gain;
		end else if (busy_q) begin
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = !busy_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

@@ hw/rtl/sspid_div.sv @@
// ----------------------------------------------------------------------------
// sspid_div
// Restoring divider by the duty scale, one quotient bit per cycle, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module sspid_div
	import sspid_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] acc,
	output logic             done,
	output logic [9:0]       duty
);

	localparam logic [63:0] LIMIT = 64'(DUTY_MAX) * 64'(DIV_SCALE);

	logic [29:0] rem_q, dvs_q;
	logic [9:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1; cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(DIV_STEPS - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= 30'(DIV_SCALE) << (DIV_STEPS - 1);
			if (acc[63]) begin
				rem_q <= '0;
				quo_q <= '0;
			end else if (acc >= LIMIT) begin
				rem_q <= '0;
				quo_q <= 10'(DUTY_MAX);
			end else begin
				rem_q <= acc[29:0];
				quo_q <= '0;
			end
		end else if (busy_q) begin
			dvs_q <= dvs_q >> 1;
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= quo_q | (10'd1 << (4'(DIV_STEPS - 1) - cnt_q));
			end
		end
	end

	assign done = busy_q && cnt_q == 4'(DIV_STEPS - 1);
	assign duty = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/sspid_checker.sv @@
// ----------------------------------------------------------------------------
// sspid_checker
// Port-level checks of the PID core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sspid_checker
	import sspid_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	`AST_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
	`AST_NOW(a_duty_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[9:0] <= 10'(DUTY_MAX), "duty above maximum")
	`AST_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")

endmodule

bind staged_setpoint_incremental_pid_core sspid_checker u_sspid_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire
